@@ hw/rtl/crsfrc_pkg.sv @@
`default_nettype none

package crsfrc_pkg;

  // Frame store geometry
  localparam int unsigned MaxFrame = 64;
  localparam int unsigned AddrW    = $clog2(MaxFrame);
  localparam int unsigned PosW     = $clog2(MaxFrame + 1);

  // Channel layout: sixteen 11-bit channels packed from byte 3 onward
  localparam int unsigned NumCh       = 16;
  localparam int unsigned ChW         = 11;
  localparam int unsigned FirstChByte = 3;
  localparam int unsigned AccW        = ChW + 7;
  localparam int unsigned CntW        = $clog2(AccW + 1);

  // Configuration registers
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned IdleW    = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGapLimit  = 2'd0,
    CfgAddress   = 2'd1,
    CfgFrameType = 2'd2
  } cfg_idx_e;

  localparam logic [IdleW-1:0] GapLimitRst = 10'd300;
  localparam logic [7:0]       AddressRst  = 8'd200;
  localparam logic [7:0]       TypeRst     = 8'd22;
  localparam logic [IdleW-1:0] IdleMax     = {IdleW{1'b1}};

  // Input operation codes
  typedef enum logic {
    OpByte = 1'b0,
    OpTick = 1'b1
  } op_e;

  // Request from the sequencer to the frame store
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } store_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/crsfrc_in_if.sv @@
`default_nettype none

interface crsfrc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crsfrc_out_if.sv @@
`default_nettype none

interface crsfrc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last;

  modport source (output valid, output channel_index, output channel_value, output last,
                  input ready);
  modport sink   (input valid, input channel_index, input channel_value, input last,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/crsfrc_frame_store.sv @@
`default_nettype none

module crsfrc_frame_store (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire crsfrc_pkg::store_req_t  req_i,
  output logic [7:0]                   rdata_o
);

  logic [7:0]                    mem_q [crsfrc_pkg::MaxFrame];
  logic [crsfrc_pkg::MaxFrame-1:0] vld_q;
  logic [7:0]                    rd_q;
  logic                          rd_vld_q;

  // Byte memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  // Track written entries; unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : 8'd0;

endmodule

`default_nettype wire

@@ hw/rtl/crsf_rc_channel_receiver_core.sv @@
// Receiver for RC channel frames carried on a serial byte stream.
// Input channel rx_i: each transfer is either a received byte (operation 0)
// or a one-microsecond tick with no byte (operation 1). Output channel res_o
// carries decoded channels: index, 11-bit value and a last flag on channel 15.
// Byte and tick transfers are accepted while the block is idle. A byte that
// completes a frame with matching address and type starts the unpacker: it
// reads the 22 channel bytes one at a time through the single read port of
// the frame store and shifts them through an 18-bit accumulator; each byte
// passes a fetch and a load state, each channel an emit state. rx_i is not
// ready while the unpacker runs. A stall on res_o holds the output register
// and the unpacker waits in its emit state; no result is dropped. The user
// must write configuration (gap limit, address, type) only while the block
// is idle, via cfg_we_i/cfg_idx_i/cfg_data_i; the block does not enforce it.
// Reset clears the position, length, idle counter and the store's valid bits,
// so the store reads as all zeros; registers return to 300, 0xC8 and 0x16.
`default_nettype none

module crsf_rc_channel_receiver_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  crsfrc_in_if.sink                                rx_i,
  crsfrc_out_if.source                             res_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [crsfrc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [crsfrc_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StFetch = 4'b0010,
    StLoad  = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  state_e                              state_q, state_d;
  logic [crsfrc_pkg::IdleW-1:0]        gap_limit_q;
  logic [7:0]                          address_q;
  logic [7:0]                          frame_type_q;
  logic [crsfrc_pkg::PosW-1:0]         pos_q, pos_d;
  logic [7:0]                          len_q, len_d;
  logic [crsfrc_pkg::IdleW-1:0]        idle_q, idle_d;
  logic [7:0]                          hdr0_q, hdr0_d;
  logic [7:0]                          hdr2_q, hdr2_d;
  logic [crsfrc_pkg::AddrW-1:0]        baddr_q, baddr_d;
  logic [crsfrc_pkg::AccW-1:0]         acc_q, acc_d;
  logic [crsfrc_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic [3:0]                          ch_q, ch_d;
  logic                                out_vld_q, out_vld_d;
  logic [3:0]                          out_idx_q, out_idx_d;
  logic [10:0]                         out_val_q, out_val_d;
  logic                                out_last_q, out_last_d;

  crsfrc_pkg::store_req_t              store_req;
  logic [7:0]                          store_rdata;

  logic                                in_xfer;
  logic                                out_free;
  logic [crsfrc_pkg::IdleW-1:0]        idle_inc;
  logic [crsfrc_pkg::PosW-1:0]         pos_wr;
  logic                                frame_done;
  logic [7:0]                          hdr2_eff;
  logic [crsfrc_pkg::CntW-1:0]         cnt_add;
  logic [crsfrc_pkg::CntW-1:0]         cnt_sub;

  crsfrc_frame_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  assign rx_i.ready = (state_q == StIdle);
  assign in_xfer    = rx_i.valid && rx_i.ready;
  assign out_free   = !out_vld_q || res_o.ready;

  assign idle_inc = (idle_q != crsfrc_pkg::IdleMax) ? idle_q + 1'b1 : idle_q;
  assign pos_wr   = (pos_q < crsfrc_pkg::PosW'(crsfrc_pkg::MaxFrame)) ? pos_q + 1'b1 : pos_q;
  assign len_d    = (in_xfer && rx_i.operation == crsfrc_pkg::OpByte && pos_q == 1)
                    ? rx_i.rx_byte : len_q;
  assign frame_done = (pos_wr > 1) && ({{(9-crsfrc_pkg::PosW){1'b0}}, pos_wr} ==
                                       ({1'b0, len_d} + 9'd2));
  assign hdr2_eff = (pos_q == 2) ? rx_i.rx_byte : hdr2_q;
  assign cnt_add  = cnt_q + crsfrc_pkg::CntW'(8);
  assign cnt_sub  = cnt_q - crsfrc_pkg::CntW'(crsfrc_pkg::ChW);

  // Store port: write received bytes, read channel bytes while unpacking
  always_comb begin
    store_req.we    = in_xfer && (rx_i.operation == crsfrc_pkg::OpByte) &&
                      (pos_q < crsfrc_pkg::PosW'(crsfrc_pkg::MaxFrame));
    store_req.waddr = pos_q[crsfrc_pkg::AddrW-1:0];
    store_req.wdata = rx_i.rx_byte;
    store_req.re    = (state_q == StFetch);
    store_req.raddr = baddr_q;
  end

  // Frame assembly and unpack sequencer
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    idle_d     = idle_q;
    hdr0_d     = hdr0_q;
    hdr2_d     = hdr2_q;
    baddr_d    = baddr_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    ch_d       = ch_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (rx_i.operation == crsfrc_pkg::OpTick) begin
            // count idle time, drop a stale partial frame
            idle_d = idle_inc;
            if (pos_q != 0 && idle_inc > gap_limit_q) begin
              pos_d = '0;
            end
          end else begin
            idle_d = '0;
            if (store_req.we && pos_q == 0) hdr0_d = rx_i.rx_byte;
            if (store_req.we && pos_q == 2) hdr2_d = rx_i.rx_byte;
            pos_d = pos_wr;
            if (frame_done) begin
              pos_d = '0;
              if (hdr0_q == address_q && hdr2_eff == frame_type_q) begin
                state_d = StFetch;
                baddr_d = crsfrc_pkg::AddrW'(crsfrc_pkg::FirstChByte);
                acc_d   = '0;
                cnt_d   = '0;
                ch_d    = '0;
              end
            end
          end
        end
      end
      StFetch: begin
        state_d = StLoad;
      end
      StLoad: begin
        // append the byte above the bits already held
        acc_d   = acc_q | (crsfrc_pkg::AccW'(store_rdata) << cnt_q);
        cnt_d   = cnt_add;
        baddr_d = baddr_q + 1'b1;
        state_d = (cnt_add >= crsfrc_pkg::CntW'(crsfrc_pkg::ChW)) ? StEmit : StFetch;
      end
      StEmit: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_idx_d  = ch_q;
          out_val_d  = acc_q[crsfrc_pkg::ChW-1:0];
          out_last_d = (ch_q == 4'(crsfrc_pkg::NumCh - 1));
          acc_d      = acc_q >> crsfrc_pkg::ChW;
          cnt_d      = cnt_sub;
          ch_d       = ch_q + 1'b1;
          if (ch_q == 4'(crsfrc_pkg::NumCh - 1)) begin
            state_d = StIdle;
          end else if (cnt_sub >= crsfrc_pkg::CntW'(crsfrc_pkg::ChW)) begin
            state_d = StEmit;
          end else begin
            state_d = StFetch;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      pos_q     <= '0;
      len_q     <= '0;
      idle_q    <= '0;
      hdr0_q    <= '0;
      hdr2_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      idle_q    <= idle_d;
      hdr0_q    <= hdr0_d;
      hdr2_q    <= hdr2_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q  <= crsfrc_pkg::GapLimitRst;
      address_q    <= crsfrc_pkg::AddressRst;
      frame_type_q <= crsfrc_pkg::TypeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crsfrc_pkg::CfgGapLimit:  gap_limit_q  <= cfg_data_i;
        crsfrc_pkg::CfgAddress:   address_q    <= cfg_data_i[7:0];
        crsfrc_pkg::CfgFrameType: frame_type_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Unpacker datapath and output register
  always_ff @(posedge clk_i) begin
    baddr_q    <= baddr_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    ch_q       <= ch_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.channel_index = out_idx_q;
  assign res_o.channel_value = out_val_q;
  assign res_o.last          = out_last_q;

endmodule

`default_nettype wire
